// ===== hdl/otb_pkg.sv =====
// otb_pkg: shared types and constants for the one-shot timer bank
// no dependencies; imported by otb_store and one_shot_timer_bank_unit
`default_nettype none

package otb_pkg;

	localparam int TICK_W = 32;
	localparam int TIMER_ID_W = 4;

	typedef enum logic [1:0] {
		ACT_SET_PERIOD = 2'd0,
		ACT_START      = 2'd1,
		ACT_STOP       = 2'd2,
		ACT_SCAN       = 2'd3
	} otb_action_t;

	// write strobes towards the entry store
	typedef struct packed {
		logic to_we;
		logic st_we;
	} otb_wr_t;

endpackage

`default_nettype wire

// ===== hdl/otb_store.sv =====
// otb_store: per-timer start time and timeout memories, one write and one
// registered read port each; timeout reads as zero until first written
// depends on otb_pkg
`default_nettype none

module otb_store import otb_pkg::*; #(
	parameter int TIMER_COUNT = 16,
	parameter int IW = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire otb_wr_t           wr,
	input  wire logic [IW-1:0]     waddr,
	input  wire logic [TICK_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [IW-1:0]     raddr,
	output logic      [TICK_W-1:0] start_s1,
	output logic      [TICK_W-1:0] timeout_s1
);

	logic [TICK_W-1:0] start_mem [TIMER_COUNT];
	logic [TICK_W-1:0] to_mem [TIMER_COUNT];
	logic [TIMER_COUNT-1:0] to_written_q;
	logic [TICK_W-1:0] to_raw_s1;
	logic to_ok_s1;

	always_ff @(posedge clk) begin
		if (wr.st_we) begin
			start_mem[waddr] <= wdata;
		end
		if (wr.to_we) begin
			to_mem[waddr] <= wdata;
		end
		if (re) begin
			start_s1 <= start_mem[raddr];
			to_raw_s1 <= to_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			to_written_q <= '0;
			to_ok_s1 <= 1'b0;
		end else begin
			if (wr.to_we) begin
				to_written_q[waddr] <= 1'b1;
			end
			if (re) begin
				to_ok_s1 <= to_written_q[raddr];
			end
		end
	end

	assign timeout_s1 = to_ok_s1 ? to_raw_s1 : '0;

endmodule

`default_nettype wire

// ===== hdl/one_shot_timer_bank_unit.sv =====
// one_shot_timer_bank_unit: one-shot tick timer bank with expiry scan; uses otb_pkg, otb_store
// set, start and stop each present one result; a scan reads one entry per cycle while the output
// is not stalled, presents a result for each expired timer, then a final result marked last
// throughput: one transaction in flight, the next taken once the last result is registered
// reset: asynchronous, all timers stopped, timeouts read as zero until first written
`default_nettype none

module one_shot_timer_bank_unit import otb_pkg::*; #(
	parameter int TIMER_COUNT = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [1:0]            action,
	input  wire logic [TIMER_ID_W-1:0] timer_id,
	input  wire logic [TICK_W-1:0]     period,
	input  wire logic [TICK_W-1:0]     now,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [TIMER_ID_W-1:0]      expired_id,
	output logic                       fired,
	output logic                       running,
	output logic                       last
);

	localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
	localparam int CW = $clog2(TIMER_COUNT + 1);
	localparam logic [CW-1:0] CNT_END = CW'(TIMER_COUNT);

	typedef struct packed {
		logic vld;
		logic fin;
	} tok_t;

	otb_action_t act;
	logic accept;
	logic adv;
	logic in_id_ok;
	logic [31:0] in_id_ext;
	logic [IW-1:0] in_addr;
	otb_wr_t wr;
	logic [TICK_W-1:0] wdata;

	logic busy_q;
	logic issuing_q;
	logic scan_q;
	logic id_ok_q;
	logic [IW-1:0] id_addr_q;
	logic [TICK_W-1:0] now_q;
	logic [CW-1:0] cnt_q;
	logic [TIMER_COUNT-1:0] active_q;

	logic issue_ent;
	logic issue_fin;
	logic [IW-1:0] raddr;

	tok_t tok_s1;
	logic [IW-1:0] idx_s1;
	logic [TICK_W-1:0] start_s1;
	logic [TICK_W-1:0] timeout_s1;

	tok_t tok_s2;
	logic [IW-1:0] idx_s2;
	logic [TICK_W-1:0] deadline_s2;

	logic [TICK_W-1:0] diff;
	logic expired;

	logic out_valid_q;
	logic [IW-1:0] out_idx_q;
	logic fired_q;
	logic running_q;
	logic last_q;
	logic [31:0] out_idx_ext;

	assign act = otb_action_t'(action);
	assign accept = in_valid && !busy_q;
	assign in_stall = busy_q;
	assign adv = !out_valid_q || !out_stall;

	assign in_id_ext = 32'(timer_id);
	assign in_id_ok = in_id_ext < 32'(TIMER_COUNT);
	assign in_addr = in_id_ext[IW-1:0];

	always_comb begin
		wr.to_we = 1'b0;
		wr.st_we = 1'b0;
		wdata = now;
		unique case (act)
			ACT_SET_PERIOD: begin
				wr.to_we = accept && in_id_ok;
				wdata = (period == '0) ? TICK_W'(1) : period;
			end
			ACT_START: begin
				wr.st_we = accept && in_id_ok;
			end
			ACT_STOP: begin
			end
			ACT_SCAN: begin
			end
			default: begin
			end
		endcase
	end

	assign issue_ent = issuing_q && scan_q && (cnt_q != CNT_END);
	assign issue_fin = issuing_q && !issue_ent;
	assign raddr = issue_ent ? cnt_q[IW-1:0] : '0;

	otb_store #(
		.TIMER_COUNT(TIMER_COUNT),
		.IW(IW)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.wr(wr),
		.waddr(in_addr),
		.wdata(wdata),
		.re(adv),
		.raddr(raddr),
		.start_s1(start_s1),
		.timeout_s1(timeout_s1)
	);

	// wrap-safe expiry test
	assign diff = now_q - deadline_s2;
	assign expired = active_q[idx_s2] && !diff[TICK_W-1];

	// transaction control and entry issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			issuing_q <= 1'b0;
			scan_q <= 1'b0;
			id_ok_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				issuing_q <= 1'b1;
				scan_q <= (act == ACT_SCAN);
				id_ok_q <= in_id_ok;
				cnt_q <= '0;
			end else if (adv) begin
				if (issue_ent) begin
					cnt_q <= cnt_q + CW'(1);
				end
				if (issue_fin) begin
					issuing_q <= 1'b0;
				end
				if (tok_s2.vld && tok_s2.fin) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_addr_q <= in_addr;
			now_q <= now;
		end
	end

	// running marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else begin
			if (accept && in_id_ok && act == ACT_START) begin
				active_q[in_addr] <= 1'b1;
			end
			if (accept && in_id_ok && act == ACT_STOP) begin
				active_q[in_addr] <= 1'b0;
			end
			if (adv && tok_s2.vld && !tok_s2.fin && expired) begin
				active_q[idx_s2] <= 1'b0;
			end
		end
	end

	// read, deadline and result stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			tok_s1.vld <= issue_ent || issue_fin;
			tok_s1.fin <= issue_fin;
			tok_s2 <= tok_s1;
			out_valid_q <= tok_s2.vld && (tok_s2.fin || expired);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1 <= raddr;
			idx_s2 <= idx_s1;
			deadline_s2 <= start_s1 + timeout_s1;
			out_idx_q <= tok_s2.fin ? '0 : idx_s2;
			fired_q <= !tok_s2.fin;
			running_q <= tok_s2.fin && id_ok_q && active_q[id_addr_q];
			last_q <= tok_s2.fin;
		end
	end

	assign out_idx_ext = 32'(out_idx_q);
	assign out_valid = out_valid_q;
	assign expired_id = out_idx_ext[TIMER_ID_W-1:0];
	assign fired = fired_q;
	assign running = running_q;
	assign last = last_q;

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !tok_s1.vld && !tok_s2.vld && !issuing_q)
		else $error("tokens in flight while idle");

	a_issue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		issuing_q |-> busy_q)
		else $error("entry issue outside a transaction");

	a_fire_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && fired_q |-> !active_q[out_idx_q])
		else $error("expired timer still running");

	a_period_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		wr.to_we |-> wdata != '0)
		else $error("zero timeout written");

	a_fin_order: assert property (@(posedge clk) disable iff (!arst_n)
		tok_s2.vld && tok_s2.fin |-> !tok_s1.vld)
		else $error("entry behind final token");

endmodule

`default_nettype wire

// ===== tb/sv/one_shot_timer_bank_unit_tb.sv =====
// one_shot_timer_bank_unit_tb: self-checking bench for the one-shot timer bank
// drives set, start, stop and scan transactions, predicts every result in-bench
// depends on otb_pkg and one_shot_timer_bank_unit
`timescale 1ns / 1ps

module one_shot_timer_bank_unit_tb;
	import otb_pkg::*;

	localparam int NUM_TIMERS = 16;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [TIMER_ID_W-1:0] expired_id;
		logic                  fired;
		logic                  running;
		logic                  last;
	} timer_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	otb_action_t           action = ACT_SET_PERIOD;
	logic [TIMER_ID_W-1:0] timer_id = '0;
	logic [TICK_W-1:0]     period = '0;
	logic [TICK_W-1:0]     now = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [TIMER_ID_W-1:0] expired_id;
	logic                  fired;
	logic                  running;
	logic                  last;

	// predicted timer bank state
	logic [TICK_W-1:0] start_stamp [NUM_TIMERS];
	logic [TICK_W-1:0] timeout_len [NUM_TIMERS];
	logic              armed [NUM_TIMERS];

	timer_result_t expected_results [$];
	logic [TICK_W-1:0] tick_now = '0;
	bit idle_on = 1'b1;
	int stall_left = 0;
	int quiet_cycles = 0;
	int mismatch_cnt = 0;

	one_shot_timer_bank_unit #(
		.TIMER_COUNT(NUM_TIMERS)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.timer_id   (timer_id),
		.period     (period),
		.now        (now),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.expired_id (expired_id),
		.fired      (fired),
		.running    (running),
		.last       (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver back-pressure in random bursts
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 4);
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic void predict_timer_bank(input otb_action_t act,
			input logic [TIMER_ID_W-1:0] id, input logic [TICK_W-1:0] per,
			input logic [TICK_W-1:0] stamp);
		logic [TICK_W-1:0] deadline;
		logic [TICK_W-1:0] slack;
		timer_result_t res;
		case (act)
			ACT_SET_PERIOD: begin
				timeout_len[id] = (per == '0) ? 32'd1 : per;
			end
			ACT_START: begin
				start_stamp[id] = stamp;
				armed[id] = 1'b1;
			end
			ACT_STOP: begin
				armed[id] = 1'b0;
			end
			default: begin
				for (int i = 0; i < NUM_TIMERS; i++) begin
					if (armed[i]) begin
						deadline = start_stamp[i] + timeout_len[i];
						slack = stamp - deadline;
						if (!slack[TICK_W-1]) begin
							armed[i] = 1'b0;
							res = '{expired_id: i[TIMER_ID_W-1:0], fired: 1'b1,
								running: 1'b0, last: 1'b0};
							expected_results.push_back(res);
						end
					end
				end
			end
		endcase
		res = '{expired_id: '0, fired: 1'b0, running: armed[id], last: 1'b1};
		expected_results.push_back(res);
	endfunction

	task automatic send_item(input otb_action_t act, input logic [TIMER_ID_W-1:0] id,
			input logic [TICK_W-1:0] per, input logic [TICK_W-1:0] stamp);
		int gap;
		gap = 0;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		timer_id <= id;
		period <= per;
		now <= stamp;
		do @(posedge clk); while (in_stall);
		predict_timer_bank(act, id, per, stamp);
	endtask

	// result checker and watchdog
	always @(posedge clk) begin
		timer_result_t got;
		timer_result_t want;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("one_shot_timer_bank_unit_tb: FAIL");
				$finish;
			end
			if (out_valid && !out_stall) begin
				got = '{expired_id: expired_id, fired: fired, running: running, last: last};
				if (expected_results.size() == 0) begin
					mismatch_cnt <= mismatch_cnt + 1;
					if (mismatch_cnt < 10)
						$display("unexpected result: id=%0d fired=%b running=%b last=%b",
							got.expired_id, got.fired, got.running, got.last);
				end else begin
					want = expected_results.pop_front();
					if (got.expired_id !== want.expired_id || got.fired !== want.fired ||
							got.running !== want.running || got.last !== want.last) begin
						mismatch_cnt <= mismatch_cnt + 1;
						if (mismatch_cnt < 10) begin
							$write("mismatch at %0t: exp id=%0d fired=%b running=%b last=%b, ",
								$realtime, want.expired_id, want.fired, want.running,
								want.last);
							$display("got id=%0d fired=%b running=%b last=%b",
								got.expired_id, got.fired, got.running, got.last);
						end
					end
				end
			end
		end
	end

	task automatic test_special_cases();
		// idle bank, stop on an idle timer
		send_item(ACT_SCAN, 4'd0, 32'h0, 32'h0);
		send_item(ACT_STOP, 4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// start before any period: expires on the next scan
		send_item(ACT_START, 4'd3, 32'h0, 32'hFFFF_FFFF);
		send_item(ACT_SCAN, 4'd3, 32'h0, 32'hFFFF_FFFF);
		// zero period forced to one, deadline wraps to zero
		send_item(ACT_SET_PERIOD, 4'd15, 32'h0, 32'h0);
		send_item(ACT_START, 4'd15, 32'h0, 32'hFFFF_FFFF);
		send_item(ACT_SCAN, 4'd15, 32'h0, 32'hFFFF_FFFF);
		send_item(ACT_SCAN, 4'd15, 32'h0, 32'h0);
		// half-range boundary of the signed difference
		send_item(ACT_SET_PERIOD, 4'd5, 32'h8000_0000, 32'h0);
		send_item(ACT_START, 4'd5, 32'h0, 32'h0);
		send_item(ACT_SCAN, 4'd5, 32'h0, 32'h7FFF_FFFF);
		send_item(ACT_SCAN, 4'd5, 32'h0, 32'h8000_0000);
		// full-scale period expires at once
		send_item(ACT_SET_PERIOD, 4'd7, 32'hFFFF_FFFF, 32'h0);
		send_item(ACT_START, 4'd7, 32'h0, 32'd100);
		send_item(ACT_SCAN, 4'd7, 32'h0, 32'd100);
		// new period on a running timer, then restart
		send_item(ACT_SET_PERIOD, 4'd10, 32'd50, 32'h0);
		send_item(ACT_START, 4'd10, 32'h0, 32'd1000);
		send_item(ACT_SET_PERIOD, 4'd10, 32'd10, 32'h0);
		send_item(ACT_SCAN, 4'd10, 32'h0, 32'd1010);
		send_item(ACT_START, 4'd10, 32'h0, 32'd2000);
		send_item(ACT_START, 4'd10, 32'h0, 32'd2005);
		send_item(ACT_SCAN, 4'd10, 32'h0, 32'd2014);
		send_item(ACT_SCAN, 4'd10, 32'h0, 32'd2015);
		// stop a running timer
		send_item(ACT_START, 4'd12, 32'h0, 32'h0);
		send_item(ACT_STOP, 4'd12, 32'h0, 32'h0);
		send_item(ACT_SCAN, 4'd12, 32'h0, 32'h7FFF_FFFF);
	endtask

	task automatic test_full_bank();
		send_item(ACT_SET_PERIOD, 4'd5, 32'h7FFF_FFFF, 32'h0);
		send_item(ACT_SET_PERIOD, 4'd7, 32'h0000_0100, 32'h0);
		for (int i = 0; i < NUM_TIMERS; i++)
			send_item(ACT_START, i[TIMER_ID_W-1:0], 32'h0, 32'hC000_0000);
		send_item(ACT_SCAN, 4'd0, 32'h0, 32'h3FFF_FFFF);
	endtask

	task automatic test_random_traffic(input int count);
		otb_action_t act;
		logic [TIMER_ID_W-1:0] id;
		logic [TICK_W-1:0] per;
		logic [TICK_W-1:0] stamp;
		int pick;
		for (int n = 0; n < count; n++) begin
			idle_on = !(n >= 100 && n < 150) && (n < count - 70);
			pick = $urandom_range(0, 99);
			if (pick < 4)
				tick_now = $urandom();
			else if (pick < 7)
				tick_now = 32'hFFFF_FFFF - $urandom_range(0, 40);
			else
				tick_now = tick_now + $urandom_range(0, 12);
			id = $urandom_range(0, NUM_TIMERS - 1);
			per = $urandom();
			pick = $urandom_range(0, 99);
			if (pick < 22) begin
				act = ACT_SET_PERIOD;
				pick = $urandom_range(0, 9);
				if (pick < 7)
					per = $urandom_range(0, 40);
				else if (pick == 7)
					per = 32'h0;
				else if (pick == 8)
					per = 32'hFFFF_FFFF;
			end else if (pick < 47) begin
				act = ACT_START;
			end else if (pick < 55) begin
				act = ACT_STOP;
			end else begin
				act = ACT_SCAN;
			end
			stamp = ($urandom_range(0, 9) == 0) ? $urandom() : tick_now;
			send_item(act, id, per, stamp);
		end
	endtask

	initial begin
		for (int i = 0; i < NUM_TIMERS; i++) begin
			start_stamp[i] = '0;
			timeout_len[i] = '0;
			armed[i] = 1'b0;
		end
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		test_special_cases();
		test_full_bank();
		test_random_traffic(325);
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("one_shot_timer_bank_unit_tb: PASS");
		else
			$display("one_shot_timer_bank_unit_tb: FAIL");
		$finish;
	end

endmodule
